// ===== sv/ptlm_pkg.sv =====
// Package for the per-thread load monitor: item types and fixed constants.
// No dependencies; the monitor and the testbench import it, ptlm_ram does not.
`default_nettype none

package ptlm_pkg;

  // Fixed widths (sums, quotient, divider step, config index) and the register count.
  localparam int SumW     = 48;
  localparam int QuotW    = 15;
  localparam int DivCntW  = 4;
  localparam int NumRegs  = 4;
  localparam int CfgIdxW  = 2;

  localparam logic [QuotW-1:0]   FullScale  = 15'd25600;
  localparam logic [31:0]        UnusedNode = 32'hFFFF_FFFF;
  localparam logic [DivCntW-1:0] DivLast    = 4'(QuotW - 1);

  // Action codes of an input item.
  localparam logic ActRecord = 1'b0;
  localparam logic ActTick   = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegPollA = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPollB = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPollC = 2'd2;
  localparam logic [CfgIdxW-1:0] RegPollD = 2'd3;

  typedef struct packed {
    logic        action;
    logic [3:0]  thread;
    logic [31:0] node_id;
    logic [15:0] work_count;
    logic [31:0] elapsed_cycles;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       thread_out;
    logic [QuotW-1:0] load_q8;
    logic             no_time;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/ptlm_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module ptlm_ram #(
  parameter int Width = 96,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/per_thread_load_monitor.sv =====
// Per-thread load monitor: total and idle cycle sums per thread in one RAM,
// with an iterative divider that turns them into a load figure on a tick.
// Depends on ptlm_pkg and ptlm_ram.
// Record item: RAM read, then add and write back; no result.
// Tick item: per thread an operand load, the divider steps (one quotient bit per
// cycle) and an output step that also reads the next thread.
// Output stalls hold the tick walk in its output step.
// Reset clears all sums at once through per-thread valid bits; the polling
// registers reset to all ones (unused). No clearing pass is needed.
`default_nettype none

module per_thread_load_monitor #(
  parameter int THREADS    = 16,
  parameter int POLL_SLOTS = 4
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Input items.
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire ptlm_pkg::in_item_t           in_item_i,
  // Result items.
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output ptlm_pkg::out_item_t               out_item_o,
  // Configuration writes.
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic [ptlm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_data_i
);

  import ptlm_pkg::*;

  localparam int TW   = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int MemW = 2 * SumW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_REC  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]         state_q, state_d;
  logic [31:0]        poll_q [NumRegs];
  logic [THREADS-1:0] vld_q;
  logic               rd_vld_q;
  in_item_t           rec_q;
  logic [TW-1:0]      rec_addr_q;
  logic [TW-1:0]      cnt_q;

  // Divider state.
  logic [SumW-1:0]    div_q;
  logic [SumW-1:0]    rem_q;
  logic [QuotW-1:0]   nlow_q;
  logic [QuotW-1:0]   quot_q;
  logic [DivCntW-1:0] step_q;
  logic               zero_q;
  logic               full_q;

  logic               out_vld_q;
  out_item_t          out_item_q;

  // RAM access.
  logic               rd_en;
  logic [TW-1:0]      rd_addr;
  logic               wr_en;
  logic [MemW-1:0]    wr_data;
  logic [MemW-1:0]    rd_data;

  logic               in_acc;
  logic [31:0]        thr_ext;
  logic               thr_ok;
  logic [SumW-1:0]    tot_rd, idl_rd;
  logic               poll_hit;
  logic [SumW:0]      tot_sum, idl_sum;
  logic [SumW-1:0]    tot_new, idl_new;
  logic [SumW+4:0]    idl_x25;
  logic [SumW:0]      rem_sh;
  logic               q_bit;
  logic               out_free;
  logic               out_load;
  logic [31:0]        cnt_ext;
  logic               cnt_last;
  out_item_t          out_d;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  assign thr_ext = 32'(in_item_i.thread);
  assign thr_ok  = (thr_ext < 32'(THREADS));

  assign cnt_ext  = 32'(cnt_q);
  assign cnt_last = (cnt_ext == 32'(THREADS - 1));

  // Read data of an entry cleared since reset or the last tick counts as zero.
  assign tot_rd = rd_vld_q ? rd_data[MemW-1:SumW] : '0;
  assign idl_rd = rd_vld_q ? rd_data[SumW-1:0]    : '0;

  // A node is idle polling when it matches an enabled, used polling register.
  always_comb begin
    poll_hit = 1'b0;
    for (int k = 0; k < POLL_SLOTS && k < NumRegs; k++) begin
      if (poll_q[k] != UnusedNode && poll_q[k] == rec_q.node_id) begin
        poll_hit = 1'b1;
      end
    end
  end

  // Saturating accumulate of a record.
  assign tot_sum = {1'b0, tot_rd} + (SumW + 1)'(rec_q.elapsed_cycles);
  assign idl_sum = {1'b0, idl_rd} + (SumW + 1)'(rec_q.elapsed_cycles);
  assign tot_new = tot_sum[SumW] ? '1 : tot_sum[SumW-1:0];
  always_comb begin
    idl_new = idl_rd;
    if (rec_q.work_count == 16'd0 && poll_hit) begin
      idl_new = idl_sum[SumW] ? '1 : idl_sum[SumW-1:0];
    end
  end
  assign wr_en   = (state_q == S_REC);
  assign wr_data = {tot_new, idl_new};

  // Numerator idle * 25600 = (idle * 25) << 10, built from shifts and adds.
  assign idl_x25 = ((SumW + 5)'(idl_rd) << 4) + ((SumW + 5)'(idl_rd) << 3)
                 + (SumW + 5)'(idl_rd);

  // One restoring division step per cycle.
  assign rem_sh = {rem_q, nlow_q[QuotW-1]};
  assign q_bit  = (rem_sh >= {1'b0, div_q});

  // Output register is free when empty or being taken this cycle.
  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = (state_q == S_EMIT) && out_free;

  always_comb begin
    out_d.thread_out = cnt_ext[3:0];
    out_d.no_time    = zero_q;
    out_d.last       = cnt_last;
    out_d.load_q8    = (zero_q || full_q) ? '0 : FullScale - quot_q;
  end

  // Sequencer and RAM read control.
  always_comb begin
    state_d = state_q;
    rd_en   = 1'b0;
    rd_addr = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.action == ActTick) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            state_d = S_LOAD;
          end else if (thr_ok) begin
            rd_en   = 1'b1;
            rd_addr = thr_ext[TW-1:0];
            state_d = S_REC;
          end
        end
      end
      S_REC:  state_d = S_IDLE;
      S_LOAD: state_d = S_DIV;
      S_DIV: begin
        if (step_q == '0) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          if (cnt_last) begin
            state_d = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_q + TW'(1);
            state_d = S_LOAD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ptlm_ram #(
    .Width (MemW),
    .Depth (THREADS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (rec_addr_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      cnt_q     <= '0;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      // A tick read empties the entry; a record write fills it.
      if (rd_en && state_q != S_IDLE) begin
        vld_q[rd_addr] <= 1'b0;
      end else if (rd_en && in_item_i.action == ActTick) begin
        vld_q[rd_addr] <= 1'b0;
      end
      if (wr_en) begin
        vld_q[rec_addr_q] <= 1'b1;
      end
      if (rd_en) begin
        cnt_q <= rd_addr;
      end
      if (state_q == S_LOAD) begin
        step_q <= DivLast;
      end else if (state_q == S_DIV) begin
        step_q <= step_q - 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Polling registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NumRegs; k++) begin
        poll_q[k] <= UnusedNode;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegPollA: poll_q[0] <= cfg_data_i;
        RegPollB: poll_q[1] <= cfg_data_i;
        RegPollC: poll_q[2] <= cfg_data_i;
        RegPollD: poll_q[3] <= cfg_data_i;
        default:  poll_q[0] <= poll_q[0];
      endcase
    end
  end

  // Payload registers: record capture, divider datapath, result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rec_q      <= in_item_i;
      rec_addr_q <= thr_ext[TW-1:0];
    end
    if (state_q == S_LOAD) begin
      zero_q <= (tot_rd == '0);
      full_q <= (idl_rd >= tot_rd);
      div_q  <= tot_rd;
      rem_q  <= idl_x25[SumW+4:5];
      nlow_q <= {idl_x25[4:0], 10'd0};
      quot_q <= '0;
    end else if (state_q == S_DIV) begin
      rem_q  <= q_bit ? SumW'(rem_sh - {1'b0, div_q}) : rem_sh[SumW-1:0];
      nlow_q <= {nlow_q[QuotW-2:0], 1'b0};
      quot_q <= {quot_q[QuotW-2:0], q_bit};
    end
    if (out_load) begin
      out_item_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_item_q;

  // A record never produces a result in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.action == ActRecord |=> !out_load)
    else $error("record item produced a result");

  // A computed load never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_d.load_q8 <= FullScale)
    else $error("load figure above full scale");

  // The final thread's result returns the sequencer to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_d.last |=> state_q == S_IDLE)
    else $error("tick walk did not end after the last thread");

  // A record write-back always follows a RAM read issued from idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> $past(rd_en) && $past(state_q) == S_IDLE)
    else $error("write-back without a preceding read");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for the per-thread load monitor: directed rows, then random phases.
// Depends on ptlm_pkg and per_thread_load_monitor; predicts every load figure.
`timescale 1ns / 1ps

module tb_top;
  import ptlm_pkg::*;

  localparam int NumThreads  = 16;
  localparam int PollSlots   = 4;
  localparam int IdleLimit   = 4000;
  localparam int HoldCycles  = 300;
  localparam int DrainCycles = 8;
  localparam int TailCycles  = 40;
  localparam int NumPhases   = 6;
  localparam int PhaseItems  = 38;
  localparam int LongReps    = 4;
  localparam int MaxPrints   = 100;

  typedef enum logic {
    RowItem,
    RowCfg
  } row_kind_e;

  // One row of the directed table: an item sent reps times, or a register write.
  typedef struct {
    row_kind_e            kind;
    in_item_t             item;
    int unsigned          reps;
    bit                   typed;
    logic [QuotW-1:0]     typed_load;
    logic                 typed_none;
    logic [CfgIdxW-1:0]   cfg_idx;
    logic [31:0]          cfg_data;
  } stim_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_item;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_item;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  // Predicted block state and the queue of load figures still to arrive.
  logic [SumW-1:0]    busy_total [NumThreads];
  logic [SumW-1:0]    idle_total [NumThreads];
  logic [31:0]        poll_reg   [NumRegs];
  out_item_t          load_q[$];

  int unsigned        err_cnt  = 0;
  int unsigned        idle_cnt = 0;
  bit                 quiet     = 1'b0;
  bit                 hold_req  = 1'b0;
  bit                 hold_done = 1'b0;

  per_thread_load_monitor #(
    .THREADS    (NumThreads),
    .POLL_SLOTS (PollSlots)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturating add of a run's cycles to a 48-bit sum.
  function automatic logic [SumW-1:0] sat_add(logic [SumW-1:0] a, logic [31:0] b);
    logic [SumW:0] s;
    s = {1'b0, a} + (SumW + 1)'(b);
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

  // A node counts as idle polling when an enabled, used slot holds its id.
  function automatic bit is_poll_node(logic [31:0] node);
    for (int k = 0; k < PollSlots; k++) begin
      if (poll_reg[k] != UnusedNode && poll_reg[k] == node) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one accepted item to the predicted sums; a tick queues one figure per thread.
  function automatic void account_item(in_item_t it);
    out_item_t   res;
    logic [63:0] quot;
    if (it.action == ActRecord) begin
      busy_total[it.thread] = sat_add(busy_total[it.thread], it.elapsed_cycles);
      if (it.work_count == '0 && is_poll_node(it.node_id))
        idle_total[it.thread] = sat_add(idle_total[it.thread], it.elapsed_cycles);
    end else begin
      for (int i = 0; i < NumThreads; i++) begin
        res.thread_out = 4'(i);
        res.last       = (i == NumThreads - 1);
        if (busy_total[i] == '0) begin
          res.no_time = 1'b1;
          res.load_q8 = '0;
        end else begin
          quot = (64'(idle_total[i]) * 64'(FullScale)) / 64'(busy_total[i]);
          if (quot > 64'(FullScale)) quot = 64'(FullScale);
          res.no_time = 1'b0;
          res.load_q8 = FullScale - quot[QuotW-1:0];
        end
        load_q.push_back(res);
        busy_total[i] = '0;
        idle_total[i] = '0;
      end
    end
  endfunction

  // Print one mismatch line (up to a cap) and count it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrints)
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
  endtask

  // Offer one item, with an optional idle burst first, and wait until it is taken.
  task automatic drive_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    account_item(it);
  endtask

  // Stop offering items and wait until all figures are in and the block is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    while (load_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Write one polling register while the block is idle.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    poll_reg[idx] = data;
  endtask

  function automatic stim_row_t rec_row(logic [3:0] thr, logic [31:0] node,
                                        logic [15:0] work, logic [31:0] cyc,
                                        int unsigned reps);
    stim_row_t r;
    r = '{kind: RowItem, item: '0, reps: reps, typed: 1'b0, typed_load: '0,
          typed_none: 1'b0, cfg_idx: '0, cfg_data: '0};
    r.item.action         = ActRecord;
    r.item.thread         = thr;
    r.item.node_id        = node;
    r.item.work_count     = work;
    r.item.elapsed_cycles = cyc;
    return r;
  endfunction

  // A tick row; its thread field names the thread whose figure is typed in.
  function automatic stim_row_t tick_row(logic [3:0] thr, bit typed,
                                         logic [QuotW-1:0] load, logic none);
    stim_row_t r;
    r = '{kind: RowItem, item: '0, reps: 1, typed: typed, typed_load: load,
          typed_none: none, cfg_idx: '0, cfg_data: '0};
    r.item.action         = ActTick;
    r.item.thread         = thr;
    r.item.node_id        = $urandom();
    r.item.work_count     = 16'($urandom());
    r.item.elapsed_cycles = $urandom();
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CfgIdxW-1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = '{kind: RowCfg, item: '0, reps: 0, typed: 1'b0, typed_load: '0,
          typed_none: 1'b0, cfg_idx: idx, cfg_data: data};
    return r;
  endfunction

  // Random polling id, biased toward the extremes and toward small ids.
  function automatic logic [31:0] pick_poll_id();
    case ($urandom_range(0, 4))
      0:       return UnusedNode;
      1:       return 32'h0;
      2:       return 32'($urandom_range(0, 15));
      3:       return 32'hFFFF_FFFE;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stall bursts, one long hold-off, no stalls at the end.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Compare each accepted result with the oldest predicted figure.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (load_q.size() == 0) begin
        report_mismatch("unexpected result", 32'(out_item), 0);
      end else begin
        want = load_q.pop_front();
        if (out_item.thread_out != want.thread_out)
          report_mismatch("thread_out", 32'(out_item.thread_out), 32'(want.thread_out));
        if (out_item.load_q8 != want.load_q8)
          report_mismatch("load_q8", 32'(out_item.load_q8), 32'(want.load_q8));
        if (out_item.no_time != want.no_time)
          report_mismatch("no_time", 32'(out_item.no_time), 32'(want.no_time));
        if (out_item.last != want.last)
          report_mismatch("last", 32'(out_item.last), 32'(want.last));
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IdleLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain.
  initial begin : main_seq
    stim_row_t   rows[$];
    in_item_t    it;
    out_item_t   fixed;
    int unsigned idx;

    in_valid  = 1'b0;
    in_item   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    rst_n     = 1'b0;
    for (int i = 0; i < NumRegs; i++) poll_reg[i] = UnusedNode;
    for (int i = 0; i < NumThreads; i++) begin
      busy_total[i] = '0;
      idle_total[i] = '0;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tick after reset, an all-ones node against unused slots, then the polling setup.
    rows.push_back(tick_row(4'd0, 1'b1, '0, 1'b1));
    rows.push_back(rec_row(4'd1, UnusedNode, 16'h0, 32'd100, 1));
    rows.push_back(tick_row(4'd1, 1'b1, FullScale, 1'b0));
    rows.push_back(cfg_row(RegPollA, 32'h0000_0100));
    rows.push_back(cfg_row(RegPollB, 32'h0000_0200));
    rows.push_back(cfg_row(RegPollC, 32'h0000_0000));
    rows.push_back(cfg_row(RegPollD, UnusedNode));
    // Idle, busy and zero-id polling runs on one thread.
    rows.push_back(rec_row(4'd2, 32'h0000_0100, 16'h0, 32'd1000, 1));
    rows.push_back(rec_row(4'd2, 32'h0000_0200, 16'h1, 32'd1000, 1));
    rows.push_back(rec_row(4'd2, 32'h0000_0000, 16'h0, 32'd2000, 1));
    // A thread that only polled, one whose node matches an unused slot, one with no time.
    rows.push_back(rec_row(4'd3, 32'h0000_0100, 16'h0, 32'hFFFF_FFFF, 1));
    rows.push_back(rec_row(4'd4, UnusedNode, 16'h0, 32'd5, 1));
    rows.push_back(rec_row(4'd15, 32'h0000_0300, 16'hFFFF, 32'd0, 1));
    rows.push_back(tick_row(4'd3, 1'b1, '0, 1'b0));
    // The tick just sent cleared every sum.
    rows.push_back(tick_row(4'd3, 1'b1, '0, 1'b1));
    // Long full-length runs: all idle on one thread, a tiny idle share on another.
    rows.push_back(rec_row(4'd5, 32'h0000_0200, 16'h0, 32'hFFFF_FFFF, LongReps));
    rows.push_back(rec_row(4'd6, 32'h0000_0100, 16'h1, 32'hFFFF_FFFF, LongReps));
    rows.push_back(rec_row(4'd6, 32'h0000_0100, 16'h0, 32'd12345, 1));
    rows.push_back(tick_row(4'd5, 1'b1, '0, 1'b0));

    foreach (rows[r]) begin
      if (rows[r].kind == RowCfg) begin
        write_reg(rows[r].cfg_idx, rows[r].cfg_data);
      end else begin
        for (int unsigned k = 0; k < rows[r].reps; k++) drive_item(rows[r].item);
        // The typed figure replaces the predicted one for the named thread.
        if (rows[r].typed) begin
          idx = load_q.size() - NumThreads + rows[r].item.thread;
          fixed = load_q[idx];
          fixed.load_q8 = rows[r].typed_load;
          fixed.no_time = rows[r].typed_none;
          load_q[idx] = fixed;
        end
      end
    end

    // Random phases, each with its own polling setup and ending in a tick.
    for (int p = 0; p < NumPhases; p++) begin
      if (p == 0) begin
        write_reg(RegPollA, UnusedNode);
        write_reg(RegPollB, UnusedNode);
        write_reg(RegPollC, UnusedNode);
        write_reg(RegPollD, UnusedNode);
      end else if (p == 1) begin
        write_reg(RegPollA, 32'h0000_0000);
        write_reg(RegPollB, 32'hFFFF_FFFE);
        write_reg(RegPollC, 32'h0000_0001);
        write_reg(RegPollD, 32'h8000_0000);
      end else begin
        write_reg(RegPollA, pick_poll_id());
        write_reg(RegPollB, pick_poll_id());
        write_reg(RegPollC, pick_poll_id());
        write_reg(RegPollD, pick_poll_id());
      end
      if (p == 2) hold_req = 1'b1;
      if (p == NumPhases - 1) quiet = 1'b1;
      for (int k = 0; k < PhaseItems; k++) begin
        // Early ticks in the hold-off phase fill the block while results wait.
        if (k == PhaseItems - 1 || (p == 2 && k < 3) || $urandom_range(0, 11) == 0)
          it.action = ActTick;
        else
          it.action = ActRecord;
        it.thread = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
          0, 1, 2: it.node_id = poll_reg[$urandom_range(0, NumRegs - 1)];
          3:       it.node_id = UnusedNode;
          4:       it.node_id = 32'($urandom_range(0, 15));
          default: it.node_id = $urandom();
        endcase
        if ($urandom_range(0, 1) == 0)
          it.work_count = '0;
        else if ($urandom_range(0, 3) == 0)
          it.work_count = 16'hFFFF;
        else
          it.work_count = 16'($urandom_range(1, 65535));
        case ($urandom_range(0, 3))
          0:       it.elapsed_cycles = $urandom();
          1:       it.elapsed_cycles = $urandom_range(0, 1000);
          2:       it.elapsed_cycles = 32'hFFFF_FFFF;
          default: it.elapsed_cycles = $urandom_range(0, 100000);
        endcase
        drive_item(it);
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
